/* hdl/iso8601_datetime_to_utc_parser_assert.svh */
// assertion macros for the dateTime parser checker
`ifndef ISO8601_DATETIME_TO_UTC_PARSER_ASSERT_SVH
`define ISO8601_DATETIME_TO_UTC_PARSER_ASSERT_SVH

// same-cycle implication
`define IDTU_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IDTU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// delayed implication
`define IDTU_ASSERT_AFTER2(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

/* hdl/idtu_pkg.sv */
// shared types, constants and helpers of the dateTime parser
`timescale 1ns / 1ps

package idtu_pkg;

  localparam int CHAR_W      = 8;
  localparam int YEAR_W      = 16;
  localparam int FRAC_DIGITS = 9;
  localparam int ACC_W       = 30;

  localparam logic [ACC_W-1:0] YEAR_MAX = ACC_W'((64'd1 << YEAR_W) - 64'd1);
  localparam logic [ACC_W-1:0] ACC_CAP  = ACC_W'(64'd1 << YEAR_W);

  localparam int PAYLOAD_W  = 1 + YEAR_W + 4 + 5 + 5 + 6 + 6 + ACC_W;
  localparam int OUT_DATA_W = ((PAYLOAD_W + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // fields of one string after its last character
  typedef struct packed {
    logic              err;
    logic              bc;
    logic              leap;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [ACC_W-1:0]  frac;
    logic [3:0]        frac_k;
    logic              off_neg;
    logic [3:0]        off_hour;
    logic [5:0]        off_minute;
  } fields_t;

  typedef struct packed {
    logic              valid_res;
    logic              is_bc;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [ACC_W-1:0]  nanosecond;
  } result_t;

  function automatic logic [4:0] days_in(input logic leap, input logic [3:0] month);
    logic [4:0] dim;
    if (month < MONTH_JAN || month > MONTH_DEC) begin
      dim = 5'd31;
    end else begin
      dim = MONTH_DAYS[month - 4'd1] + 5'((month == MONTH_FEB) && leap);
    end
    return dim;
  endfunction

endpackage

/* hdl/iso8601_datetime_to_utc_parser.sv */
// dateTime string to utc parser, top level
// one character transaction per cycle while s_tready is high, no gaps between strings
// the final character fills the snapshot register, whose result enters the result register when the output is free
// stage one parses the character and snapshots the fields, stage two folds the offset to utc
// a stalled output holds its result and one more snapshot before input stalls
// synchronous reset clears the parse state and the valid flags of both pipeline registers at once
`timescale 1ns / 1ps

module iso8601_datetime_to_utc_parser import idtu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CHAR_W-1:0]     s_tdata,   // char_code
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // is_bc, year, month, day, hour, minute, second,
                                           // nanosecond, zero fill
  output logic                  m_tuser    // valid_res
);

  logic    snap_valid;
  logic    snap_ready;
  fields_t snap;
  result_t res;

  idtu_char_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .char_code  (s_tdata),
    .last_char  (s_tlast),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  idtu_utc_fold u_fold (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tuser = res.valid_res;
  assign m_tdata = {{(OUT_DATA_W-PAYLOAD_W){1'b0}}, res.nanosecond, res.second, res.minute,
                    res.hour, res.day, res.month, res.year, res.is_bc};

endmodule

/* hdl/idtu_char_parse.sv */
// per-character field parser with end-of-string snapshot register
`timescale 1ns / 1ps

module idtu_char_parse import idtu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  output logic              snap_valid,
  output fields_t           snap,
  input  logic              snap_ready
);

  typedef enum logic [3:0] {
    PH_YEAR      = 4'd0,
    PH_MONTH     = 4'd1,
    PH_DAY       = 4'd2,
    PH_HOUR      = 4'd3,
    PH_MINUTE    = 4'd4,
    PH_SECOND    = 4'd5,
    PH_FRAC      = 4'd6,
    PH_ZULU      = 4'd7,
    PH_TZ_HOUR   = 4'd8,
    PH_TZ_MINUTE = 4'd9
  } phase_t;

  // year residue mod 25, for the century leap rule
  function automatic logic [4:0] mod25(input logic [4:0] r, input logic [3:0] d);
    logic [7:0]  x;
    logic [13:0] p;
    logic [7:0]  q;
    x = 8'(r) * 8'd10 + 8'(d);
    p = 14'(x) * 14'd41;
    q = 8'(p[13:10]);
    return 5'(x - q * 8'd25);
  endfunction

  phase_t           phase;
  phase_t           phase_next;
  logic [3:0]       dc;
  logic [ACC_W-1:0] acc;
  logic             lead_zero;
  logic [4:0]       r25;
  fields_t          f;
  fields_t          f_next;

  logic              accept;
  logic              is_digit;
  logic [3:0]        dig;
  logic              busy;
  logic              zulu_hit;
  logic              bc_minus;
  logic              take_digit;
  logic              close_char;
  logic              close_end;
  logic              do_close;
  logic [ACC_W+3:0]  acc_mac;
  logic [ACC_W-1:0]  acc_upd;
  logic [3:0]        dc_upd;
  logic              lz_upd;
  logic [4:0]        r25_upd;
  logic [CHAR_W-1:0] ch;
  logic              two;
  logic              err_c;
  logic              at_err;
  logic              at_neg;
  phase_t            at_phase;

  assign in_ready = !snap_valid || snap_ready;
  assign accept   = in_valid && in_ready;

  assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dig        = char_code[3:0];
  assign busy       = !f.err && (phase != PH_ZULU);
  assign zulu_hit   = !f.err && (phase == PH_ZULU);
  assign bc_minus   = busy && (phase == PH_YEAR) && (char_code == CH_MINUS) &&
                      (dc == 4'd0) && !f.bc;
  assign take_digit = busy && is_digit;
  assign close_char = busy && !is_digit && !bc_minus;
  assign close_end  = last_char && busy && !close_char;
  assign do_close   = close_char || close_end;

  assign acc_mac = (ACC_W+4)'(acc) * (ACC_W+4)'(10) + (ACC_W+4)'(dig);

  always_comb begin
    acc_upd = acc;
    if (take_digit) begin
      if (phase == PH_FRAC) begin
        if (dc < 4'(FRAC_DIGITS)) begin
          acc_upd = acc_mac[ACC_W-1:0];
        end
      end else if (acc_mac > (ACC_W+4)'(ACC_CAP)) begin
        acc_upd = ACC_CAP;
      end else begin
        acc_upd = acc_mac[ACC_W-1:0];
      end
    end
  end

  assign dc_upd  = (take_digit && dc != 4'hF) ? dc + 4'd1 : dc;
  assign lz_upd  = lead_zero ||
                   (take_digit && phase == PH_YEAR && dc == 4'd0 && dig == 4'd0);
  assign r25_upd = (take_digit && phase == PH_YEAR) ? mod25(r25, dig) : r25;

  assign ch  = close_char ? char_code : '0;
  assign two = (dc_upd == 4'd2);

  // what may follow the seconds or the fraction
  always_comb begin
    at_err   = 1'b0;
    at_neg   = f.off_neg;
    at_phase = phase;
    if (!close_end) begin
      priority if (ch == CH_Z) begin
        at_phase = PH_ZULU;
      end else if (ch == CH_DOT && phase == PH_SECOND) begin
        at_phase = PH_FRAC;
      end else if (ch == CH_PLUS || ch == CH_MINUS) begin
        at_neg   = (ch == CH_MINUS);
        at_phase = PH_TZ_HOUR;
      end else begin
        at_err = 1'b1;
      end
    end
  end

  always_comb begin
    f_next     = f;
    f_next.bc  = f.bc || bc_minus;
    phase_next = phase;
    err_c      = 1'b0;
    if (do_close) begin
      unique case (phase)
        PH_YEAR: begin
          err_c = (lz_upd ? dc_upd != 4'd4 : dc_upd < 4'd4) || acc_upd == '0 ||
                  acc_upd > YEAR_MAX || close_end || ch != CH_MINUS;
          f_next.year = acc_upd[YEAR_W-1:0];
          f_next.leap = (acc_upd[1:0] == 2'd0) &&
                        (r25_upd != 5'd0 || acc_upd[3:0] == 4'd0);
          phase_next  = PH_MONTH;
        end
        PH_MONTH: begin
          err_c = !two || acc_upd < ACC_W'(1) || acc_upd > ACC_W'(12) ||
                  close_end || ch != CH_MINUS;
          f_next.month = acc_upd[3:0];
          phase_next   = PH_DAY;
        end
        PH_DAY: begin
          err_c = !two || acc_upd < ACC_W'(1) ||
                  acc_upd > ACC_W'(days_in(f.leap, f.month)) ||
                  close_end || ch != CH_T;
          f_next.day = acc_upd[4:0];
          phase_next = PH_HOUR;
        end
        PH_HOUR: begin
          err_c = !two || acc_upd > ACC_W'(24) || close_end || ch != CH_COLON;
          f_next.hour = acc_upd[4:0];
          phase_next  = PH_MINUTE;
        end
        PH_MINUTE: begin
          err_c = !two || acc_upd > ACC_W'(59) || close_end || ch != CH_COLON;
          f_next.minute = acc_upd[5:0];
          phase_next    = PH_SECOND;
        end
        PH_SECOND: begin
          if (!two || acc_upd > ACC_W'(60)) begin
            err_c = 1'b1;
          end else begin
            f_next.second  = acc_upd[5:0];
            f_next.off_neg = at_neg;
            phase_next     = at_phase;
            err_c          = at_err;
          end
        end
        PH_FRAC: begin
          if (dc_upd == 4'd0) begin
            err_c = 1'b1;
          end else begin
            f_next.frac    = acc_upd;
            f_next.frac_k  = (dc_upd < 4'(FRAC_DIGITS)) ? dc_upd : 4'(FRAC_DIGITS);
            f_next.off_neg = at_neg;
            phase_next     = at_phase;
            err_c          = at_err;
          end
        end
        PH_TZ_HOUR: begin
          err_c = !two || acc_upd > ACC_W'(14) || close_end || ch != CH_COLON;
          f_next.off_hour = acc_upd[3:0];
          phase_next      = PH_TZ_MINUTE;
        end
        default: begin
          err_c = !two || acc_upd > ACC_W'(59) ||
                  (f.off_hour == 4'd14 && acc_upd != '0) || !close_end;
          f_next.off_minute = acc_upd[5:0];
        end
      endcase
    end
    // a separator as the last character leaves an empty field behind it
    f_next.err = f.err || zulu_hit || err_c ||
                 (last_char && close_char && phase_next != PH_ZULU);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_YEAR;
      dc         <= '0;
      acc        <= '0;
      lead_zero  <= 1'b0;
      r25        <= '0;
      f          <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last_char) begin
          phase     <= PH_YEAR;
          dc        <= '0;
          acc       <= '0;
          lead_zero <= 1'b0;
          r25       <= '0;
          f         <= '0;
          snap      <= f_next;
        end else begin
          phase     <= phase_next;
          dc        <= do_close ? '0 : dc_upd;
          acc       <= do_close ? '0 : acc_upd;
          lead_zero <= lz_upd;
          r25       <= do_close ? '0 : r25_upd;
          f         <= f_next;
        end
      end
      if (accept && last_char) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/idtu_utc_fold.sv */
// utc fold of the offset and day rollover into the result register
`timescale 1ns / 1ps

module idtu_utc_fold import idtu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    snap_valid,
  output logic    snap_ready,
  input  fields_t snap,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  // scale of k kept fractional digits to nanoseconds
  function automatic logic [ACC_W-1:0] frac_scale(input logic [3:0] k);
    logic [ACC_W-1:0] s;
    unique case (k)
      4'd1:    s = ACC_W'(100000000);
      4'd2:    s = ACC_W'(10000000);
      4'd3:    s = ACC_W'(1000000);
      4'd4:    s = ACC_W'(100000);
      4'd5:    s = ACC_W'(10000);
      4'd6:    s = ACC_W'(1000);
      4'd7:    s = ACC_W'(100);
      4'd8:    s = ACC_W'(10);
      default: s = ACC_W'(1);
    endcase
    return s;
  endfunction

  logic              load;
  logic              roll;
  logic              roll_bad;
  logic [4:0]        h0;
  logic              borrow;
  logic [6:0]        mi_p;
  logic [5:0]        t_p;
  logic              prev;
  logic [5:0]        h_p;
  logic [6:0]        ms;
  logic              carry;
  logic [6:0]        mi_m;
  logic [5:0]        hs;
  logic              nxt;
  logic [5:0]        h_m;
  logic              inc;
  logic              dec;
  logic [4:0]        dim_cur;
  logic [4:0]        dim_prev;
  logic [YEAR_W:0]   y_in;
  logic [YEAR_W:0]   y_out;
  logic [3:0]        m_out;
  logic [4:0]        d_out;
  logic              bc_out;
  logic [5:0]        h_out;
  logic [6:0]        mi_out;
  logic              ok;
  logic [ACC_W-1:0]  ns;
  result_t           res_next;

  assign snap_ready = !res_valid || res_ready;
  assign load       = snap_valid && snap_ready;

  assign roll     = (snap.hour == 5'd24);
  assign roll_bad = roll && (snap.minute != '0 || snap.second != '0 || snap.frac != '0);
  assign h0       = roll ? 5'd0 : snap.hour;

  // plus offset: subtract
  assign borrow = snap.minute < snap.off_minute;
  assign mi_p   = borrow ? 7'(snap.minute) + 7'd60 - 7'(snap.off_minute)
                         : 7'(snap.minute) - 7'(snap.off_minute);
  assign t_p    = 6'(h0) + 6'd24 - 6'(borrow) - 6'(snap.off_hour);
  assign prev   = t_p < 6'd24;
  assign h_p    = prev ? t_p : t_p - 6'd24;

  // minus offset: add
  assign ms    = 7'(snap.minute) + 7'(snap.off_minute);
  assign carry = ms >= 7'd60;
  assign mi_m  = carry ? ms - 7'd60 : ms;
  assign hs    = 6'(h0) + 6'(snap.off_hour) + 6'(carry);
  assign nxt   = hs >= 6'd24;
  assign h_m   = nxt ? hs - 6'd24 : hs;

  // rollover and a plus offset that borrows a day cancel out
  assign inc = roll ? !(!snap.off_neg && prev) : (snap.off_neg && nxt);
  assign dec = !roll && !snap.off_neg && prev;

  assign h_out  = snap.off_neg ? h_m : h_p;
  assign mi_out = snap.off_neg ? mi_m : mi_p;

  assign dim_cur  = days_in(snap.leap, snap.month);
  assign dim_prev = days_in(snap.leap, snap.month - 4'd1);
  assign y_in     = (YEAR_W+1)'(snap.year);

  always_comb begin
    y_out  = y_in;
    m_out  = snap.month;
    d_out  = snap.day;
    bc_out = snap.bc;
    if (inc) begin
      if (snap.day < dim_cur) begin
        d_out = snap.day + 5'd1;
      end else if (snap.month < MONTH_DEC) begin
        d_out = 5'd1;
        m_out = snap.month + 4'd1;
      end else begin
        d_out = 5'd1;
        m_out = MONTH_JAN;
        if (!snap.bc) begin
          y_out = y_in + (YEAR_W+1)'(1);
        end else if (y_in == (YEAR_W+1)'(1)) begin
          bc_out = 1'b0;
        end else begin
          y_out = y_in - (YEAR_W+1)'(1);
        end
      end
    end else if (dec) begin
      if (snap.day > 5'd1) begin
        d_out = snap.day - 5'd1;
      end else if (snap.month > MONTH_JAN) begin
        m_out = snap.month - 4'd1;
        d_out = dim_prev;
      end else begin
        m_out = MONTH_DEC;
        d_out = 5'd31;
        if (snap.bc) begin
          y_out = y_in + (YEAR_W+1)'(1);
        end else if (y_in == (YEAR_W+1)'(1)) begin
          bc_out = 1'b1;
        end else begin
          y_out = y_in - (YEAR_W+1)'(1);
        end
      end
    end
  end

  assign ok = !snap.err && !roll_bad && y_out != '0 && !y_out[YEAR_W];
  assign ns = snap.frac * frac_scale(snap.frac_k);

  always_comb begin
    res_next = '0;
    if (ok) begin
      res_next.valid_res  = 1'b1;
      res_next.is_bc      = bc_out;
      res_next.year       = y_out[YEAR_W-1:0];
      res_next.month      = m_out;
      res_next.day        = d_out;
      res_next.hour       = h_out[4:0];
      res_next.minute     = mi_out[5:0];
      res_next.second     = snap.second;
      res_next.nanosecond = ns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (load) begin
        res <= res_next;
      end
    end
  end

endmodule

/* hdl/idtu_checker.sv */
// port checker for the dateTime parser and its bind
`timescale 1ns / 1ps
`include "iso8601_datetime_to_utc_parser_assert.svh"

module idtu_checker import idtu_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tlast,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  localparam int MO_LO = 1 + YEAR_W;
  localparam int DY_LO = MO_LO + 4;
  localparam int HR_LO = DY_LO + 5;
  localparam int MI_LO = HR_LO + 5;
  localparam int SE_LO = MI_LO + 6;
  localparam int NS_LO = SE_LO + 6;

  logic [3:0]       mo;
  logic [4:0]       dy;
  logic [4:0]       hr;
  logic [5:0]       mi;
  logic [5:0]       se;
  logic [ACC_W-1:0] ns;
  logic             fields_ok;
  logic             last_xfer;

  assign mo = m_tdata[MO_LO +: 4];
  assign dy = m_tdata[DY_LO +: 5];
  assign hr = m_tdata[HR_LO +: 5];
  assign mi = m_tdata[MI_LO +: 6];
  assign se = m_tdata[SE_LO +: 6];
  assign ns = m_tdata[NS_LO +: ACC_W];

  assign fields_ok = mo >= 4'd1 && mo <= 4'd12 && dy >= 5'd1 && hr < 5'd24 &&
                     mi < 6'd60 && se <= 6'd60 && ns < ACC_W'(1000000000);
  assign last_xfer = s_tvalid && s_tready && s_tlast;

  `IDTU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `IDTU_ASSERT_IMPLY(a_bad_zero, m_tvalid && !m_tuser, m_tdata == '0, "invalid result with nonzero fields")
  `IDTU_ASSERT_IMPLY(a_good_range, m_tvalid && m_tuser, fields_ok, "valid result field out of range")
  `IDTU_ASSERT_AFTER2(a_result_due, last_xfer, m_tvalid, "no result after final character")

endmodule

bind iso8601_datetime_to_utc_parser idtu_checker u_idtu_checker (.*);

/* tb/sv/idtu_utc_checker.sv */
// checker for the dateTime parser: tracks the character stream, predicts and compares utc results
`timescale 1ns / 1ps

module idtu_utc_checker import idtu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [CHAR_W-1:0]     s_tdata,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  output int                    mismatches,
  output int                    pending
);

  typedef enum logic [3:0] {
    PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND,
    PH_FRAC, PH_ZULU, PH_TZ_HOUR, PH_TZ_MINUTE
  } phase_e;

  phase_e          phase;
  int unsigned     ndig;
  longint unsigned acc;
  longint unsigned yr;
  longint unsigned frac_ns;
  bit              err;
  bit              bc;
  bit              lead0;
  bit              off_neg;
  int unsigned     mon, dy, hr, mn, sec, off_h, off_m;

  result_t         utc_results_q [$];
  result_t         got_r;
  result_t         want_r;

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint unsigned got_v,
                             input longint unsigned want_v);
    if (got_v != want_v) begin
      flag_mismatch($sformatf("%s got %0d expected %0d", name, got_v, want_v));
    end
  endtask

  function automatic void reset_parser();
    phase   = PH_YEAR;
    ndig    = 0;
    acc     = 0;
    err     = 0;
    bc      = 0;
    lead0   = 0;
    yr      = 0;
    mon     = 0;
    dy      = 0;
    hr      = 0;
    mn      = 0;
    sec     = 0;
    frac_ns = 0;
    off_neg = 0;
    off_h   = 0;
    off_m   = 0;
  endfunction

  function automatic int unsigned month_len(input longint unsigned y, input int unsigned m);
    bit          leap;
    int unsigned len;
    if (m < 1 || m > 12) begin
      len = 31;
    end else begin
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      len  = MONTH_DAYS[m - 1] + ((m == MONTH_FEB && leap) ? 1 : 0);
    end
    return len;
  endfunction

  function automatic void day_fwd(inout longint unsigned y, inout int unsigned m,
                                  inout int unsigned d, inout bit b);
    d++;
    if (d > month_len(y, m)) begin
      d = 1;
      m++;
      if (m > 12) begin
        m = 1;
        if (b) begin
          y--;
          if (y == 0) begin
            y = 1;
            b = 0;
          end
        end else begin
          y++;
        end
      end
    end
  endfunction

  function automatic void day_back(inout longint unsigned y, inout int unsigned m,
                                   inout int unsigned d, inout bit b);
    if (d > 1) begin
      d--;
    end else begin
      if (m > 1) begin
        m--;
      end else begin
        m = 12;
        if (b) begin
          y++;
        end else begin
          y--;
          if (y == 0) begin
            y = 1;
            b = 1;
          end
        end
      end
      d = month_len(y, m);
    end
  endfunction

  // what may follow the seconds or the fraction
  function automatic void after_seconds(input logic [CHAR_W-1:0] c, input bit at_end);
    if (!at_end) begin
      if (c == CH_Z) begin
        phase = PH_ZULU;
      end else if (c == CH_DOT && phase == PH_SECOND) begin
        phase = PH_FRAC;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        off_neg = (c == CH_MINUS);
        phase   = PH_TZ_HOUR;
      end else begin
        err = 1;
      end
    end
  endfunction

  function automatic void close_field(input logic [CHAR_W-1:0] c, input bit at_end);
    longint unsigned v;
    int unsigned     k;
    bit              two;
    v   = acc;
    two = (ndig == 2);
    case (phase)
      PH_YEAR: begin
        if ((lead0 ? ndig != 4 : ndig < 4) || v == 0 || v > YEAR_MAX || at_end ||
            c != CH_MINUS) err = 1;
        yr    = v;
        phase = PH_MONTH;
      end
      PH_MONTH: begin
        if (!two || v < 1 || v > 12 || at_end || c != CH_MINUS) err = 1;
        mon   = v & 15;
        phase = PH_DAY;
      end
      PH_DAY: begin
        if (!two || v < 1 || v > month_len(yr, mon) || at_end || c != CH_T) err = 1;
        dy    = v & 31;
        phase = PH_HOUR;
      end
      PH_HOUR: begin
        if (!two || v > 24 || at_end || c != CH_COLON) err = 1;
        hr    = v & 31;
        phase = PH_MINUTE;
      end
      PH_MINUTE: begin
        if (!two || v > 59 || at_end || c != CH_COLON) err = 1;
        mn    = v & 63;
        phase = PH_SECOND;
      end
      PH_SECOND: begin
        if (!two || v > 60) begin
          err = 1;
        end else begin
          sec = v;
          after_seconds(c, at_end);
        end
      end
      PH_FRAC: begin
        if (ndig == 0) begin
          err = 1;
        end else begin
          k = (ndig < FRAC_DIGITS) ? ndig : FRAC_DIGITS;
          while (k < 9) begin
            v = v * 10;
            k++;
          end
          frac_ns = v & 64'h3FFF_FFFF;
          after_seconds(c, at_end);
        end
      end
      PH_TZ_HOUR: begin
        if (!two || v > 14 || at_end || c != CH_COLON) err = 1;
        off_h = v & 15;
        phase = PH_TZ_MINUTE;
      end
      default: begin
        if (!two || v > 59 || (off_h == 14 && v != 0) || !at_end) err = 1;
        off_m = v & 63;
      end
    endcase
    ndig = 0;
    acc  = 0;
  endfunction

  function automatic void parse_char(input logic [CHAR_W-1:0] c);
    int unsigned d;
    if (err) begin
      // rest of the string is swallowed
    end else if (phase == PH_ZULU) begin
      err = 1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      if (phase == PH_YEAR && ndig == 0 && d == 0) lead0 = 1;
      if (phase == PH_FRAC) begin
        if (ndig < FRAC_DIGITS) acc = acc * 10 + d;
      end else begin
        acc = acc * 10 + d;
        if (acc > ACC_CAP) acc = ACC_CAP;
      end
      if (ndig < 15) ndig++;
    end else if (phase == PH_YEAR && c == CH_MINUS && ndig == 0 && !bc) begin
      bc = 1;
    end else begin
      close_field(c, 1'b0);
    end
  endfunction

  // fold offset into utc and queue the expected result
  function automatic void finish_string();
    result_t         r;
    longint unsigned y;
    int unsigned     m, d, h, mi;
    bit              b, ok;
    if (!err && phase != PH_ZULU) close_field('0, 1'b1);
    ok = !err;
    y  = yr;
    m  = mon;
    d  = dy;
    h  = hr;
    mi = mn;
    b  = bc;
    if (ok && h == 24) begin
      if (mi != 0 || sec != 0 || frac_ns != 0) begin
        ok = 0;
      end else begin
        h = 0;
        day_fwd(y, m, d, b);
      end
    end
    if (ok) begin
      if (!off_neg) begin
        if (mi < off_m) begin
          mi = mi + 60 - off_m;
          h  = h + 23;
        end else begin
          mi = mi - off_m;
          h  = h + 24;
        end
        if (h < 24 + off_h) begin
          h = h - off_h;
          day_back(y, m, d, b);
        end else begin
          h = h - off_h - 24;
        end
      end else begin
        mi = mi + off_m;
        h  = h + off_h;
        if (mi >= 60) begin
          mi = mi - 60;
          h++;
        end
        if (h >= 24) begin
          h = h - 24;
          day_fwd(y, m, d, b);
        end
      end
      if (y == 0 || y > YEAR_MAX) ok = 0;
    end
    r = '0;
    if (ok) begin
      r.valid_res  = 1'b1;
      r.is_bc      = b;
      r.year       = y[YEAR_W-1:0];
      r.month      = m[3:0];
      r.day        = d[4:0];
      r.hour       = h[4:0];
      r.minute     = mi[5:0];
      r.second     = sec[5:0];
      r.nanosecond = frac_ns[ACC_W-1:0];
    end
    utc_results_q.push_back(r);
    reset_parser();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_parser();
      utc_results_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        parse_char(s_tdata);
        if (s_tlast) finish_string();
      end
      if (m_tvalid && m_tready) begin
        got_r.valid_res = m_tuser;
        {got_r.nanosecond, got_r.second, got_r.minute, got_r.hour, got_r.day,
         got_r.month, got_r.year, got_r.is_bc} = m_tdata[PAYLOAD_W-1:0];
        if (utc_results_q.size() == 0) begin
          flag_mismatch("result transaction with no string pending");
        end else begin
          want_r = utc_results_q.pop_front();
          check_field("valid_res", got_r.valid_res, want_r.valid_res);
          check_field("is_bc", got_r.is_bc, want_r.is_bc);
          check_field("year", got_r.year, want_r.year);
          check_field("month", got_r.month, want_r.month);
          check_field("day", got_r.day, want_r.day);
          check_field("hour", got_r.hour, want_r.hour);
          check_field("minute", got_r.minute, want_r.minute);
          check_field("second", got_r.second, want_r.second);
          check_field("nanosecond", got_r.nanosecond, want_r.nanosecond);
        end
      end
    end
    pending = utc_results_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// testbench top: clock, reset, character stimulus, result sink and verdict for the dateTime parser
`timescale 1ns / 1ps

module tb_top;
  import idtu_pkg::*;

  typedef byte unsigned text_t [$];

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [CHAR_W-1:0]     s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  int mismatches;
  int pending;
  int chars_sent;
  bit quiet;
  bit stall_req;

  string dir_texts [$] = '{
    "2024-02-29T23:59:60.123456789Z",
    "-0001-12-31T24:00:00-14:00",
    "0001-01-01T00:00:00+00:01",
    "-0001-01-01T00:00:00+01:00",
    "65535-12-31T23:59:59-00:01",
    "2023-02-29T00:00:00Z",
    "--2020-01-01T00:00:00Z",
    "2020-01-01T10:00:00Z0",
    "2020-01-01T10:00:00.1234567890123+05:30",
    "2020-01-01T24:00:01Z",
    "2020-12-31T24:00:00",
    "2020-01-01T12:00:00+14:01",
    "00123-01-01T00:00:00",
    "1900-02-29T00:00:00",
    "2000-02-29T00:30:00+14:00",
    "99999-06-15T12:00:00Z",
    "2020-06-15T12:00:00.Z",
    "2020-06-15T12:00:00-0530"
  };

  iso8601_datetime_to_utc_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  idtu_utc_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic text_t to_text(input string s);
    text_t q;
    int    i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // one string, one character transaction per byte, tlast on the final one
  task automatic send_bytes(input text_t txt);
    int i;
    for (i = 0; i < txt.size(); i++) begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= txt[i];
      s_tlast  <= (i == txt.size() - 1);
      do @(posedge clk); while (!s_tready);
      chars_sent++;
    end
  endtask

  function automatic text_t random_noise(input int unsigned n);
    text_t       q;
    int unsigned i;
    for (i = 0; i < n; i++) q.push_back($urandom_range(0, 255));
    return q;
  endfunction

  function automatic string random_datetime();
    string       t;
    int unsigned y, mo, d, h, mi, s, nf, oh, om, pick, i;
    bit          zero_tail;
    pick = $urandom_range(0, 15);
    case (pick)
      0:       y = $urandom_range(65530, 65545);
      1:       y = $urandom_range(10000, 65535);
      2:       y = $urandom_range(0, 3);
      3:       y = 100 * $urandom_range(1, 99);
      default: y = $urandom_range(1, 9999);
    endcase
    t = "";
    if ($urandom_range(0, 5) == 0) t = "-";
    if (pick == 4) begin
      t = {t, $sformatf("%06d-", y)};
    end else begin
      t = {t, $sformatf("%04d-", y)};
    end
    mo = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0, 1:    d = 1;
      2, 3:    d = $urandom_range(28, 31);
      4:       d = $urandom_range(0, 39);
      default: d = $urandom_range(1, 28);
    endcase
    case ($urandom_range(0, 9))
      0, 1:    h = 24;
      2:       h = 0;
      3:       h = 23;
      4:       h = $urandom_range(25, 99);
      default: h = $urandom_range(0, 23);
    endcase
    mi = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
    case ($urandom_range(0, 15))
      0:       s = $urandom_range(61, 99);
      1, 2:    s = 60;
      default: s = $urandom_range(0, 59);
    endcase
    zero_tail = (h == 24) && ($urandom_range(0, 3) != 0);
    if (zero_tail) begin
      mi = 0;
      s  = 0;
    end
    t = {t, $sformatf("%02d-%02dT%02d:%02d:%02d", mo, d, h, mi, s)};
    if ($urandom_range(0, 2) == 0) begin
      nf = $urandom_range(0, 13);
      t  = {t, "."};
      for (i = 0; i < nf; i++) begin
        if (zero_tail) begin
          t = {t, "0"};
        end else begin
          t = {t, $sformatf("%0d", $urandom_range(0, 9))};
        end
      end
    end
    case ($urandom_range(0, 4))
      0: ;
      1: t = {t, "Z"};
      default: begin
        oh = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 99) : $urandom_range(0, 14);
        om = (oh == 14 && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 59);
        if ($urandom_range(0, 15) == 0) om = $urandom_range(60, 99);
        if ($urandom_range(0, 1) == 1) begin
          t = {t, "-"};
        end else begin
          t = {t, "+"};
        end
        t = {t, $sformatf("%02d:%02d", oh, om)};
      end
    endcase
    return t;
  endfunction

  // result sink with random backpressure and one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        m_tready <= 1'b0;
        repeat (150) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    text_t       q;
    int          k, pos;
    int unsigned sel;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    chars_sent = 0;
    quiet      = 1'b0;
    stall_req  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_texts[k]) send_bytes(to_text(dir_texts[k]));
    q = {8'h00};
    send_bytes(q);
    q = {8'hFF};
    send_bytes(q);

    // short strings while the sink holds off, so the parser backs up
    stall_req = 1'b1;
    for (k = 0; k < 24; k++) send_bytes(random_noise($urandom_range(1, 3)));

    while (chars_sent < 560) begin
      quiet = (chars_sent >= 500);
      sel   = $urandom_range(0, 9);
      if (sel == 0) begin
        q = random_noise($urandom_range(1, 6));
      end else begin
        q = to_text(random_datetime());
        if (sel <= 2) begin
          pos = $urandom_range(0, q.size() - 1);
          case ($urandom_range(0, 3))
            0: q[pos] = $urandom_range(0, 255);
            1: if (q.size() > 1) q.delete(pos);
            2: q = q[0:pos];
            default: q.insert(pos, $urandom_range(0, 255));
          endcase
        end
      end
      send_bytes(q);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/idtu_pkg.sv
hdl/idtu_char_parse.sv
hdl/idtu_utc_fold.sv
hdl/iso8601_datetime_to_utc_parser.sv
hdl/idtu_checker.sv
tb/sv/idtu_utc_checker.sv
tb/sv/tb_top.sv
